/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/nds_pkg.sv */
// ---------------------------------------------------------------------------
// nds_pkg
// Types and constants shared by the NAL unit DQId scanner modules.
// ---------------------------------------------------------------------------
package nds_pkg;

  // Default layer table depth, entry 0 included
  localparam int TABLE_DEPTH_DEF = 8;

  // Field widths
  localparam int IDX_W  = 4;
  localparam int DQID_W = 7;
  localparam int NT_W   = 5;
  localparam int LEN_W  = 32;

  // NAL unit types that carry a scalable header extension
  localparam logic [NT_W-1:0] NAL_TYPE_PREFIX = 5'd14;
  localparam logic [NT_W-1:0] NAL_TYPE_EXT    = 5'd20;

  // Result kinds
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IDX_LEN_PREFIXED = 1'b0;
  localparam logic CFG_IDX_LEN_BYTES    = 1'b1;

  // Length prefix byte count limits and reset value
  localparam logic [2:0] LEN_BYTES_MIN = 3'd1;
  localparam logic [2:0] LEN_BYTES_MAX = 3'd4;
  localparam logic [2:0] LEN_BYTES_RST = 3'd4;

  // Parser phase
  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  entry_index;
    logic [DQID_W-1:0] layer_dqid;
    logic [DQID_W-1:0] dqid_max;
    logic              run_last;
  } result_t;

  // Results caused by one accepted byte, entry first
  typedef struct packed {
    logic    entry_vld;
    result_t entry;
    logic    summ_vld;
    result_t summ;
  } push_t;

endpackage

/* hdl/svc_nal_dqid_scanner.sv */
// ---------------------------------------------------------------------------
// svc_nal_dqid_scanner
// Scans access unit bytes for NAL units and reports the layer DQId table.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser  tlast
//  in_      in   [7:0] data_byte                         -      au_last
//  out_     out  [3:0] entry_index [10:4] layer_dqid     kind   run_last
//                [17:11] dqid_max, rest zero
//  cfg_     in   cfg_index 0 length_prefixed, 1 length_field_bytes
//
//  One byte is parsed per cycle while in_tready is high; its results land
//  in a three-slot queue on the next edge.
//  A byte causing a table entry and the summary fills two queue slots;
//  in_tready is low while two or more results wait.
//  Synchronous reset clears the parse state, length_prefixed to 0 and
//  length_field_bytes to 4. A stalled output holds its result.
// ---------------------------------------------------------------------------
module svc_nal_dqid_scanner #(
  parameter int TABLE_DEPTH = nds_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [3:0] entry_index, [10:4] layer_dqid, [17:11] dqid_max
  output logic [0:0]  out_tuser,   // [0] kind
  output logic        out_tlast
);

  logic             in_acc;
  nds_pkg::push_t   push;
  nds_pkg::result_t res;

  assign in_acc = in_tvalid && in_tready;

  // Parse bytes
  nds_parser #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push)
  );

  // Queue results
  nds_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (in_tready),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (res)
  );

  // Pack result fields
  assign out_tdata = {6'd0, res.dqid_max, res.layer_dqid, res.entry_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.run_last;

endmodule

/* hdl/nds_parser.sv */
// ---------------------------------------------------------------------------
// nds_parser
// Per-byte NAL unit parser: delimiting, header decode, DQId tracking.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nds_parser #(
  parameter int TABLE_DEPTH = nds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_wdata,
  input  logic                in_acc,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output nds_pkg::push_t      push
);

  localparam int ENT_W = $clog2(TABLE_DEPTH + 1);

  logic                            len_pref_r;
  logic [2:0]                      len_bytes_r;
  logic [1:0]                      zero_run_r, zero_run_nxt;
  nds_pkg::phase_t                 phase_r, phase_nxt;
  logic [2:0]                      psn_r, psn_nxt;
  logic [nds_pkg::LEN_W-1:0]       nbl_r, nbl_nxt;
  logic [1:0]                      hpos_r, hpos_nxt;
  logic [nds_pkg::NT_W-1:0]        nal_type_r, nal_type_nxt;
  logic [nds_pkg::DQID_W-1:0]      max_dqid_r, max_dqid_nxt;
  logic [ENT_W-1:0]                entries_r, entries_nxt;

  logic [2:0]                      nb;
  logic [2:0]                      psn_inc;
  logic [nds_pkg::LEN_W-1:0]       nbl_shift;
  logic                            start_det;
  logic                            hdr_en;
  logic [nds_pkg::DQID_W-1:0]      dq;
  logic [31:0]                     ent_idx32, sum_idx32;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_pref_r  <= 1'b0;
      len_bytes_r <= nds_pkg::LEN_BYTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nds_pkg::CFG_IDX_LEN_PREFIXED: len_pref_r  <= cfg_wdata[0];
        nds_pkg::CFG_IDX_LEN_BYTES:    len_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
      phase_r    <= nds_pkg::PH_SEEK;
      psn_r      <= 3'd0;
      nbl_r      <= '0;
      hpos_r     <= 2'd0;
      nal_type_r <= '0;
      max_dqid_r <= '0;
      entries_r  <= ENT_W'(1);
    end else begin
      zero_run_r <= zero_run_nxt;
      phase_r    <= phase_nxt;
      psn_r      <= psn_nxt;
      nbl_r      <= nbl_nxt;
      hpos_r     <= hpos_nxt;
      nal_type_r <= nal_type_nxt;
      max_dqid_r <= max_dqid_nxt;
      entries_r  <= entries_nxt;
    end
  end

  // Clamp prefix width, detect start code, select header bytes
  always_comb begin
    if (len_bytes_r < nds_pkg::LEN_BYTES_MIN) begin
      nb = nds_pkg::LEN_BYTES_MIN;
    end else if (len_bytes_r > nds_pkg::LEN_BYTES_MAX) begin
      nb = nds_pkg::LEN_BYTES_MAX;
    end else begin
      nb = len_bytes_r;
    end
    psn_inc   = psn_r + 3'd1;
    nbl_shift = {nbl_r[nds_pkg::LEN_W-9:0], in_byte};
    start_det = (in_byte == 8'd1) && (zero_run_r >= 2'd2);
    hdr_en    = in_acc && (phase_r == nds_pkg::PH_HEADER) && (len_pref_r || !start_det);
    // Masks 0x70 and 0x0f do not overlap, so the sum is the low seven bits
    dq        = in_byte[6:0];
  end

  // Next state and results for one byte
  always_comb begin
    zero_run_nxt = zero_run_r;
    phase_nxt    = phase_r;
    psn_nxt      = psn_r;
    nbl_nxt      = nbl_r;
    hpos_nxt     = hpos_r;
    nal_type_nxt = nal_type_r;
    max_dqid_nxt = max_dqid_r;
    entries_nxt  = entries_r;
    ent_idx32    = 32'(entries_r);
    push         = '0;

    // Header byte decode
    if (hdr_en) begin
      case (hpos_r)
        2'd0: begin
          nal_type_nxt = in_byte[nds_pkg::NT_W-1:0];
          hpos_nxt     = 2'd1;
        end
        2'd1: begin
          hpos_nxt = 2'd2;
        end
        default: begin
          if ((nal_type_r == nds_pkg::NAL_TYPE_PREFIX) ||
              (nal_type_r == nds_pkg::NAL_TYPE_EXT)) begin
            if ((dq > max_dqid_r) && (entries_r < ENT_W'(TABLE_DEPTH))) begin
              max_dqid_nxt = dq;
              if (nal_type_r == nds_pkg::NAL_TYPE_EXT) begin
                push.entry_vld         = 1'b1;
                push.entry.kind        = nds_pkg::KIND_ENTRY;
                push.entry.entry_index = ent_idx32[nds_pkg::IDX_W-1:0];
                push.entry.layer_dqid  = dq;
                push.entry.dqid_max    = dq;
                push.entry.run_last    = !in_last;
                entries_nxt            = entries_r + ENT_W'(1);
              end
            end
          end
          phase_nxt = nds_pkg::PH_BODY;
        end
      endcase
    end

    // Unit delimiting
    if (in_acc) begin
      if (len_pref_r) begin
        if (phase_r == nds_pkg::PH_SEEK) begin
          nbl_nxt = nbl_shift;
          if (psn_inc >= nb) begin
            psn_nxt = 3'd0;
            if (nbl_shift != '0) begin
              phase_nxt = nds_pkg::PH_HEADER;
              hpos_nxt  = 2'd0;
            end
          end else begin
            psn_nxt = psn_inc;
          end
        end else if (nbl_r <= nds_pkg::LEN_W'(1)) begin
          nbl_nxt   = '0;
          phase_nxt = nds_pkg::PH_SEEK;
          psn_nxt   = 3'd0;
        end else begin
          nbl_nxt = nbl_r - nds_pkg::LEN_W'(1);
        end
      end else if (start_det) begin
        zero_run_nxt = 2'd0;
        phase_nxt    = nds_pkg::PH_HEADER;
        hpos_nxt     = 2'd0;
      end else if (in_byte == 8'd0) begin
        if (zero_run_r < 2'd2) begin
          zero_run_nxt = zero_run_r + 2'd1;
        end
      end else begin
        zero_run_nxt = 2'd0;
      end
    end

    // Emit summary and clear on the last byte
    sum_idx32 = 32'(entries_nxt);
    if (in_acc && in_last) begin
      push.summ_vld         = 1'b1;
      push.summ.kind        = nds_pkg::KIND_SUMMARY;
      push.summ.entry_index = sum_idx32[nds_pkg::IDX_W-1:0];
      push.summ.layer_dqid  = '0;
      push.summ.dqid_max    = max_dqid_nxt;
      push.summ.run_last    = 1'b1;
      zero_run_nxt = 2'd0;
      phase_nxt    = nds_pkg::PH_SEEK;
      psn_nxt      = 3'd0;
      nbl_nxt      = '0;
      hpos_nxt     = 2'd0;
      nal_type_nxt = '0;
      max_dqid_nxt = '0;
      entries_nxt  = ENT_W'(1);
    end
  end

  `ASSERT_CLK(a_entries_range, (entries_r >= ENT_W'(1)) && (entries_r <= ENT_W'(TABLE_DEPTH)), "entry count out of range")
  `ASSERT_CLK(a_clear_on_last, (in_acc && in_last) |=> ((entries_r == ENT_W'(1)) && (max_dqid_r == '0) && (phase_r == nds_pkg::PH_SEEK)), "state not cleared after last byte")
  `ASSERT_CLK(a_max_monotonic, (max_dqid_r < $past(max_dqid_r)) |-> $past(in_acc && in_last), "maximum fell inside an access unit")

endmodule

/* hdl/nds_result_queue.sv */
// ---------------------------------------------------------------------------
// nds_result_queue
// Three-slot result register queue; takes up to two results per request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nds_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  nds_pkg::push_t   push,
  output logic             room,
  output logic             out_vld,
  input  logic             out_rdy,
  output nds_pkg::result_t out_res
);

  localparam int DEPTH = 3;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nds_pkg::result_t   slot_r [DEPTH];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   tail0, tail1;
  logic [PTR_W-1:0]   summ_pos;
  logic [PTR_W:0]     tail_sum;
  logic               pop;
  logic [CNT_W-1:0]   n_push;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    begin
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
    end
  endfunction

  // Free slots are known from the registered count alone
  assign room    = (count_r <= CNT_W'(1));
  assign out_vld = (count_r != '0);
  assign out_res = slot_r[head_r];
  assign pop     = out_vld && out_rdy;

  // Locate write slots behind the head
  always_comb begin
    tail_sum = {1'b0, head_r} + (PTR_W + 1)'(count_r);
    if (tail_sum >= (PTR_W + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (PTR_W + 1)'(DEPTH);
    end
    tail0    = tail_sum[PTR_W-1:0];
    tail1    = ptr_inc(tail0);
    summ_pos = push.entry_vld ? tail1 : tail0;
    n_push   = CNT_W'(push.entry_vld) + CNT_W'(push.summ_vld);
    head_nxt = pop ? ptr_inc(head_r) : head_r;
    count_nxt = count_r + n_push - CNT_W'(pop);
  end

  // Hold results
  always_ff @(posedge clk) begin
    if (push.entry_vld) begin
      slot_r[tail0] <= push.entry;
    end
    if (push.summ_vld) begin
      slot_r[summ_pos] <= push.summ;
    end
  end

  // Advance head and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_CLK(a_push_room, (push.entry_vld || push.summ_vld) |-> (count_r <= CNT_W'(1)), "request pushed without room for two results")
  `ASSERT_CLK(a_drain, (pop && (count_r == CNT_W'(1)) && !push.entry_vld && !push.summ_vld) |=> !out_vld, "queue not empty after last result taken")
  `ASSERT_NEVER(a_count_range, count_r > CNT_W'(DEPTH), "queue count beyond depth")

endmodule
